>>> design/sacht_pkg.sv
// Shared types and constants for the set associative cache hit/miss tracker.
// Used by sacht_cell and set_assoc_cache_hit_miss_tracker; no dependencies.
package sacht_pkg;

   // Field widths, sized for the largest supported geometry.
   localparam int ROW_W   = 12;
   localparam int WAY_W   = 7;
   localparam int FLAT_W  = 20;
   localparam int TAG_W   = 31;
   localparam int DATA_W  = 31;
   localparam int STAMP_W = 32;
   localparam int CNT_W   = 32;
   localparam int LINE_OUT_W = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 5;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FULLY_ASSOC   = 3'd0,
      CSR_WAYS_LOG2     = 3'd1,
      CSR_LINES_LOG2    = 3'd2,
      CSR_OFFSET_BITS   = 3'd3,
      CSR_REPLACE_OLDEST = 3'd4
   } csr_index_type;

   // Running scan result that travels down the chain of cells.
   typedef struct packed {
      logic               valid;
      logic [ROW_W-1:0]   row;
      logic               decided;
      logic               hit;
      logic [ROW_W-1:0]   line_row;
      logic [WAY_W-1:0]   line_way;
      logic               vic_valid;
      logic [ROW_W-1:0]   vic_row;
      logic [WAY_W-1:0]   vic_way;
      logic [STAMP_W-1:0] vic_stamp;
   } sum_type;

   // Lookup key, held stable for the whole scan.
   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [DATA_W-1:0] data;
      logic [FLAT_W-1:0] lo;
      logic [FLAT_W-1:0] hi;
      logic              replace_oldest;
   } key_type;

   // Line write, broadcast to every cell.
   typedef struct packed {
      logic               en;
      logic               all;
      logic [ROW_W-1:0]   row;
      logic [WAY_W-1:0]   way;
      logic [TAG_W-1:0]   tag;
      logic [DATA_W-1:0]  value;
      logic [STAMP_W-1:0] stamp;
   } wr_type;

   // True when a candidate stamp beats the current victim under the policy.
   function automatic logic stamp_better(input logic replace_oldest,
                                         input logic [STAMP_W-1:0] cand,
                                         input logic [STAMP_W-1:0] cur);
      stamp_better = replace_oldest ? (cand < cur) : (cand > cur);
   endfunction

endpackage

>>> design/sacht_cell.sv
// One way of the cache: a bank of lines for that way and one scan stage.
// Depends on sacht_pkg.
module sacht_cell
   import sacht_pkg::*;
#(
   parameter int NUM_SETS = 256,
   parameter int NUM_WAYS = 8,
   parameter int WAY      = 0
) (
   input  logic    clock,
   input  logic    reset,
   input  key_type key,
   input  wr_type  wr,
   input  sum_type sum_in,
   output sum_type sum_out
);

   localparam int RW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

   logic [TAG_W-1:0]   tag_mem   [NUM_SETS];
   logic [DATA_W-1:0]  val_mem   [NUM_SETS];
   logic [STAMP_W-1:0] stamp_mem [NUM_SETS];

   sum_type            sum_ff;
   logic [TAG_W-1:0]   tag_rd_ff;
   logic [DATA_W-1:0]  val_rd_ff;
   logic [STAMP_W-1:0] stamp_rd_ff;

   logic [FLAT_W-1:0]  flat;
   logic               in_range;

   always_ff @(posedge clock) begin
      if (wr.en && (wr.all || (wr.way == WAY_W'(WAY)))) begin
         tag_mem[wr.row[RW-1:0]]   <= wr.tag;
         val_mem[wr.row[RW-1:0]]   <= wr.value;
         stamp_mem[wr.row[RW-1:0]] <= wr.stamp;
      end
      tag_rd_ff   <= tag_mem[sum_in.row[RW-1:0]];
      val_rd_ff   <= val_mem[sum_in.row[RW-1:0]];
      stamp_rd_ff <= stamp_mem[sum_in.row[RW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   assign flat = FLAT_W'(sum_ff.row) * FLAT_W'(NUM_WAYS) + FLAT_W'(WAY);
   assign in_range = (flat >= key.lo) && (flat < key.hi);

   // The first line that matches the tag or is empty decides the access.
   always_comb begin
      sum_out = sum_ff;
      if (sum_ff.valid && in_range && !sum_ff.decided) begin
         if (tag_rd_ff == key.tag) begin
            sum_out.decided  = 1'b1;
            sum_out.hit      = (val_rd_ff == key.data);
            sum_out.line_row = sum_ff.row;
            sum_out.line_way = WAY_W'(WAY);
         end else if (tag_rd_ff == '0) begin
            sum_out.decided  = 1'b1;
            sum_out.hit      = 1'b0;
            sum_out.line_row = sum_ff.row;
            sum_out.line_way = WAY_W'(WAY);
         end else if (!sum_ff.vic_valid ||
                      stamp_better(key.replace_oldest, stamp_rd_ff, sum_ff.vic_stamp)) begin
            sum_out.vic_valid = 1'b1;
            sum_out.vic_row   = sum_ff.row;
            sum_out.vic_way   = WAY_W'(WAY);
            sum_out.vic_stamp = stamp_rd_ff;
         end
      end
   end

endmodule

>>> design/set_assoc_cache_hit_miss_tracker.sv
// Top level of the cache hit/miss tracker: sequencer, row merge and counters.
// Depends on sacht_pkg and sacht_cell.
//
//   channel   handshake               payload
//   request   start, busy             req_access_address, req_access_data
//   response  rsp_valid (one cycle)   rsp_was_miss, rsp_line_touched, rsp_total_*
//   config    csr_valid, csr_ready    csr_index, csr_data
//
// A scan covers each row of NUM_WAYS lines that the set spans: one row enters
// the chain of cells per cycle. After reset, a clearing pass empties all
// lines; busy is high during it. The result strobe lasts one cycle and cannot
// be stalled.
module set_assoc_cache_hit_miss_tracker
   import sacht_pkg::*;
#(
   parameter int NUM_SETS = 256,
   parameter int NUM_WAYS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [30:0]           req_access_address,
   input  logic [30:0]           req_access_data,
   output logic                  rsp_valid,
   output logic                  rsp_was_miss,
   output logic [LINE_OUT_W-1:0] rsp_line_touched,
   output logic [CNT_W-1:0]      rsp_total_accesses,
   output logic [CNT_W-1:0]      rsp_total_misses,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int LINE_CAP = NUM_SETS * NUM_WAYS;
   localparam int MAXL     = $clog2(LINE_CAP + 1) - 1;
   localparam int MAXW     = $clog2(NUM_WAYS + 1) - 1;

   state_type state_ff, state_in;

   logic       fa_ff;
   logic [1:0] ways_ff;
   logic [3:0] lines_ff;
   logic [4:0] offset_ff;
   logic       ro_ff;

   logic [30:0]       addr_ff, data_ff;
   key_type           key_ff;
   logic [ROW_W-1:0]  first_row_ff, last_row_ff, issue_row_ff, clr_row_ff;
   logic              issue_done_ff;
   sum_type           acc_ff;
   logic [CNT_W-1:0]  acc_cnt_ff, miss_cnt_ff;

   logic                  rsp_valid_ff, rsp_miss_ff;
   logic [LINE_OUT_W-1:0] rsp_line_ff;

   sum_type chain [NUM_WAYS+1];
   wr_type  wr;

   // Address split, computed in the setup cycle.
   logic [30:0]       blk;
   logic [4:0]        lg, w, sb;
   logic [31:0]       sb_mask, n_lines;
   logic [30:0]       base, tag_c;
   logic [FLAT_W-1:0] lo_c, hi_c;

   // Result of the finished scan.
   logic             done_miss;
   logic [ROW_W-1:0] done_row;
   logic [WAY_W-1:0] done_way;
   logic [FLAT_W-1:0] done_flat;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fa_ff     <= 1'b0;
         ways_ff   <= 2'd0;
         lines_ff  <= 4'd11;
         offset_ff <= 5'd5;
         ro_ff     <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FULLY_ASSOC:    fa_ff     <= csr_data[0];
            CSR_WAYS_LOG2:      ways_ff   <= csr_data[1:0];
            CSR_LINES_LOG2:     lines_ff  <= csr_data[3:0];
            CSR_OFFSET_BITS:    offset_ff <= csr_data[4:0];
            CSR_REPLACE_OLDEST: ro_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      blk = addr_ff >> offset_ff;
      lg  = (lines_ff > 4'(MAXL)) ? 5'(MAXL) : {1'b0, lines_ff};
      w   = {3'b000, ways_ff};
      if (w > lg) w = lg;
      if (w > 5'(MAXW)) w = 5'(MAXW);
      sb      = lg - w;
      sb_mask = (32'd1 << sb) - 32'd1;
      // A fully associative set spans all lines in use, an indexed set its ways.
      n_lines = fa_ff ? (32'd1 << lg) : (32'd1 << w);
      if (fa_ff) begin
         base  = '0;
         tag_c = blk;
      end else begin
         base  = (blk & sb_mask[30:0]) << w;
         tag_c = blk >> sb;
      end
      lo_c = base[FLAT_W-1:0];
      hi_c = lo_c + n_lines[FLAT_W-1:0];
   end

   // Row feed into the first cell.
   always_comb begin
      chain[0]       = '0;
      chain[0].valid = (state_ff == ST_SCAN) && !issue_done_ff;
      chain[0].row   = issue_row_ff;
   end

   for (genvar g = 0; g < NUM_WAYS; g++) begin : g_cell
      sacht_cell #(
         .NUM_SETS(NUM_SETS),
         .NUM_WAYS(NUM_WAYS),
         .WAY     (g)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .key    (key_ff),
         .wr     (wr),
         .sum_in (chain[g]),
         .sum_out(chain[g+1])
      );
   end

   always_comb begin
      done_miss = !(acc_ff.decided && acc_ff.hit);
      done_row  = acc_ff.decided ? acc_ff.line_row : acc_ff.vic_row;
      done_way  = acc_ff.decided ? acc_ff.line_way : acc_ff.vic_way;
      done_flat = FLAT_W'(done_row) * FLAT_W'(NUM_WAYS) + FLAT_W'(done_way);
   end

   always_comb begin
      wr = '0;
      if (state_ff == ST_CLEAR) begin
         wr.en  = 1'b1;
         wr.all = 1'b1;
         wr.row = clr_row_ff;
      end else if (state_ff == ST_DONE) begin
         wr.en    = done_miss;
         wr.row   = done_row;
         wr.way   = done_way;
         wr.tag   = key_ff.tag;
         wr.value = key_ff.data;
         wr.stamp = acc_cnt_ff + 32'd1;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_row_ff == ROW_W'(NUM_SETS - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (start) state_in = ST_SETUP;
         ST_SETUP: state_in = ST_SCAN;
         ST_SCAN:  if (chain[NUM_WAYS].valid && chain[NUM_WAYS].row == last_row_ff)
                      state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_row_ff    <= '0;
         issue_done_ff <= 1'b0;
         acc_cnt_ff    <= '0;
         miss_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         acc_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b0;
         if (state_ff == ST_CLEAR) clr_row_ff <= clr_row_ff + ROW_W'(1);
         if (state_ff == ST_SETUP) begin
            issue_done_ff    <= 1'b0;
            acc_ff.decided   <= 1'b0;
            acc_ff.hit       <= 1'b0;
            acc_ff.vic_valid <= 1'b0;
         end
         if (state_ff == ST_SCAN && !issue_done_ff && issue_row_ff == last_row_ff)
            issue_done_ff <= 1'b1;
         // Row results arrive in order; the earliest decision wins.
         if (state_ff == ST_SCAN && chain[NUM_WAYS].valid && !acc_ff.decided) begin
            if (chain[NUM_WAYS].decided) begin
               acc_ff.decided  <= 1'b1;
               acc_ff.hit      <= chain[NUM_WAYS].hit;
               acc_ff.line_row <= chain[NUM_WAYS].line_row;
               acc_ff.line_way <= chain[NUM_WAYS].line_way;
            end else if (chain[NUM_WAYS].vic_valid && (!acc_ff.vic_valid ||
                         stamp_better(key_ff.replace_oldest,
                                      chain[NUM_WAYS].vic_stamp, acc_ff.vic_stamp))) begin
               acc_ff.vic_valid <= 1'b1;
               acc_ff.vic_row   <= chain[NUM_WAYS].vic_row;
               acc_ff.vic_way   <= chain[NUM_WAYS].vic_way;
               acc_ff.vic_stamp <= chain[NUM_WAYS].vic_stamp;
            end
         end
         if (state_ff == ST_DONE) begin
            acc_cnt_ff   <= acc_cnt_ff + 32'd1;
            if (done_miss) miss_cnt_ff <= miss_cnt_ff + 32'd1;
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         addr_ff <= req_access_address;
         data_ff <= req_access_data;
      end
      if (state_ff == ST_SETUP) begin
         key_ff.tag            <= tag_c;
         key_ff.data           <= data_ff;
         key_ff.lo             <= lo_c;
         key_ff.hi             <= hi_c;
         key_ff.replace_oldest <= ro_ff;
         first_row_ff <= ROW_W'(lo_c / NUM_WAYS);
         last_row_ff  <= ROW_W'((hi_c - FLAT_W'(1)) / NUM_WAYS);
         issue_row_ff <= ROW_W'(lo_c / NUM_WAYS);
      end else if (state_ff == ST_SCAN && !issue_done_ff) begin
         issue_row_ff <= issue_row_ff + ROW_W'(1);
      end
      if (state_ff == ST_DONE) begin
         rsp_miss_ff <= done_miss;
         rsp_line_ff <= LINE_OUT_W'(done_flat);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_was_miss       = rsp_miss_ff;
   assign rsp_line_touched   = rsp_line_ff;
   assign rsp_total_accesses = acc_cnt_ff;
   assign rsp_total_misses   = miss_cnt_ff;

   // Every scan ends with either a deciding line or a victim.
   a_done_has_line: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> (acc_ff.decided || acc_ff.vic_valid))
      else $error("scan finished without a line");

   // The result strobe never lasts longer than one cycle.
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held");

   // The access count moves exactly when a result is produced.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_total_accesses == $past(acc_cnt_ff) + 32'd1)
      else $error("access count out of step");

   // No row enters the chain of cells while idle.
   a_chain_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !chain[0].valid)
      else $error("row issued while idle");

   // First row never lies past the last row.
   a_row_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> first_row_ff <= last_row_ff)
      else $error("row range reversed");

endmodule
